>>> rtl/plm_pkg.sv
// Shared types, codes and constants of the priority LED multiplexer.
package plm_pkg;

	// Flash mode codes carried by a request.
	typedef enum logic [1:0] {
		FLASH_SOLID   = 2'd0,
		FLASH_TIMED   = 2'd1,
		FLASH_HW      = 2'd2,
		FLASH_INVALID = 2'd3
	} flash_mode_t;

	// Slot codes, in rising priority.
	localparam logic [1:0] SLOT_BATTERY   = 2'd0;
	localparam logic [1:0] SLOT_NOTIFY    = 2'd1;
	localparam logic [1:0] SLOT_ATTENTION = 2'd2;
	localparam logic [1:0] SLOT_NONE      = 2'd3;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_ADJUST_RED      = 3'd0,
		REG_ADJUST_GREEN    = 3'd1,
		REG_ADJUST_BLUE     = 3'd2,
		REG_LEVEL_BATTERY   = 3'd3,
		REG_LEVEL_NOTIFY    = 3'd4,
		REG_LEVEL_ATTENTION = 3'd5
	} cfg_reg_t;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 8;

	// Colour used when an attention request is turned into a solid one.
	localparam logic [23:0] ATTN_FIX_COLOR = 24'h0000ff;

	// ceil(2^32 / 255): floor(x * RECIP_255 / 2^32) equals x / 255 for all
	// products of three bytes.
	localparam logic [24:0] RECIP_255 = 25'h1010102;

	// Reset value of every calibration and level register.
	localparam logic [7:0] FULL_SCALE = 8'hff;

	typedef enum logic [1:0] {
		TOP_IDLE   = 2'd0,
		TOP_CALC   = 2'd1,
		TOP_COMMIT = 2'd2
	} top_state_t;

	typedef enum logic {
		SC_IDLE = 1'b0,
		SC_RUN  = 1'b1
	} sc_state_t;

	// Status of the colour scaler towards the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} sc_stat_t;

endpackage

>>> rtl/plm_ifs.sv
// Handshake channel interfaces of the priority LED multiplexer.
interface plm_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  slot;
	logic [23:0] rgb;
	logic [1:0]  flash_mode;
	logic [15:0] on_time;
	logic [15:0] off_time;

	modport source (output valid, output slot, output rgb, output flash_mode,
		output on_time, output off_time, input ready);
	modport sink (input valid, input slot, input rgb, input flash_mode,
		input on_time, input off_time, output ready);
endinterface

interface plm_rsp_if;
	logic              valid;
	logic              ready;
	logic              status;
	logic              led_update;
	logic [31:0]       led_color;
	logic [15:0]       led_on_time;
	logic [15:0]       led_off_time;
	logic signed [2:0] shown_slot;

	modport source (output valid, output status, output led_update, output led_color,
		output led_on_time, output led_off_time, output shown_slot, input ready);
	modport sink (input valid, input status, input led_update, input led_color,
		input led_on_time, input led_off_time, input shown_slot, output ready);
endinterface

interface plm_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [plm_pkg::CFG_INDEX_W-1:0] index;
	logic [plm_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/plm_scaler.sv
// Colour calibration through one shared multiplier, one channel at a time.
module plm_scaler (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [23:0]          rgb,
	input  logic [7:0]           level,
	input  logic [2:0][7:0]      adjust,
	output plm_pkg::sc_stat_t    stat,
	output logic [31:0]          color
);

	plm_pkg::sc_state_t state_q, state_d;
	logic [1:0]  ch_q;
	logic [1:0]  ph_q;
	logic [47:0] acc_q;
	logic [31:0] color_q;
	logic [23:0] rgb_q;
	logic [7:0]  level_q;
	logic        done_q;

	logic [7:0]  chan_byte;
	logic [4:0]  chan_shift;
	logic [23:0] op_a;
	logic [24:0] op_b;
	logic [47:0] prod;
	logic        last_step;

	always_comb begin
		unique case (ch_q)
			2'd0: begin
				chan_byte  = rgb_q[23:16];
				chan_shift = 5'd16;
			end
			2'd1: begin
				chan_byte  = rgb_q[15:8];
				chan_shift = 5'd8;
			end
			default: begin
				chan_byte  = rgb_q[7:0];
				chan_shift = 5'd0;
			end
		endcase
	end

	// Phase 0: byte times calibration, phase 1: times level,
	// phase 2: times the reciprocal of 255, phase 3: pack the quotient.
	always_comb begin
		unique case (ph_q)
			2'd0: begin
				op_a = 24'(chan_byte);
				op_b = 25'(adjust[ch_q]);
			end
			2'd1: begin
				op_a = acc_q[23:0];
				op_b = 25'(level_q);
			end
			default: begin
				op_a = acc_q[23:0];
				op_b = plm_pkg::RECIP_255;
			end
		endcase
	end

	assign prod      = 48'(op_a) * 48'(op_b);
	assign last_step = (ph_q == 2'd3) && (ch_q == 2'd2);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			plm_pkg::SC_IDLE: begin
				if (start) begin
					state_d = plm_pkg::SC_RUN;
				end
			end
			plm_pkg::SC_RUN: begin
				if (last_step) begin
					state_d = plm_pkg::SC_IDLE;
				end
			end
			default: state_d = plm_pkg::SC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plm_pkg::SC_IDLE;
			ch_q    <= 2'd0;
			ph_q    <= 2'd0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == plm_pkg::SC_RUN) && last_step;
			if (state_q == plm_pkg::SC_IDLE) begin
				ch_q <= 2'd0;
				ph_q <= 2'd0;
			end else begin
				ph_q <= ph_q + 2'd1;
				if (ph_q == 2'd3) begin
					ch_q <= ch_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == plm_pkg::SC_IDLE) begin
			if (start) begin
				rgb_q   <= rgb;
				level_q <= level;
				color_q <= 32'd0;
			end
		end else if (ph_q == 2'd3) begin
			color_q <= color_q + (32'(acc_q[47:32]) << chan_shift);
		end else begin
			acc_q <= prod;
		end
	end

	assign stat.busy = (state_q == plm_pkg::SC_RUN);
	assign stat.done = done_q;
	assign color     = color_q;

endmodule

>>> rtl/priority_led_multiplexer.sv
// Top level of the priority LED multiplexer: request sequencing, slot store and LED choice.
//
//  channel | modport | beat carries
//  --------+---------+-------------------------------------------------------------
//  req     | sink    | slot, rgb, flash_mode, on_time, off_time
//  rsp     | source  | status, led_update, led_color, led_on_time, led_off_time,
//          |         | shown_slot
//  cfg     | sink    | index, data (calibration and level registers, always ready)
//
// A valid request goes from its beat to the calculation state, where the colour
// scaler runs four steps per colour channel on its single multiplier, twelve in all,
// and then to the commit state, which waits for the output register to be free.
// A rejected request (invalid flash mode or slot three) skips the calculation state.
// Only one request is in work at a time; the next one is taken once the result has
// moved into the output register, even if the sink has not yet taken it.
// Reset clears all slots to dark, shows no slot and sets every register to full scale.
module priority_led_multiplexer (
	input  logic       clk,
	input  logic       arst_n,
	plm_req_if.sink    req,
	plm_rsp_if.source  rsp,
	plm_cfg_if.sink    cfg
);

	// Configuration registers.
	logic [2:0][7:0] adjust_q;
	logic [2:0][7:0] level_q;

	// Per-slot store and the slot currently on the LED.
	logic [2:0][31:0] slot_color_q;
	logic [2:0][15:0] slot_on_q;
	logic [2:0][15:0] slot_off_q;
	logic             shown_v_q;
	logic [1:0]       shown_q;

	// Sequencer and the request in work.
	plm_pkg::top_state_t state_q, state_d;
	logic [1:0]  slot_q;
	logic        reject_q;
	logic [15:0] on_q;
	logic [15:0] off_q;

	// Output register.
	logic              rsp_valid_q;
	logic              status_q;
	logic              update_q;
	logic [31:0]       color_out_q;
	logic [15:0]       on_out_q;
	logic [15:0]       off_out_q;
	logic signed [2:0] shown_out_q;

	// Attention fix-up and request decode, straight off the input beat.
	logic [23:0] rgb_fix;
	logic [1:0]  mode_fix;
	logic        reject_in;
	logic [7:0]  level_sel;
	logic        req_beat;
	logic        sc_start;

	plm_pkg::sc_stat_t sc_stat;
	logic [31:0]       sc_color;

	// Commit decision.
	logic              commit;
	logic              out_status;
	logic              out_update;
	logic [31:0]       out_color;
	logic [15:0]       out_on;
	logic [15:0]       out_off;
	logic              new_shown_v;
	logic [1:0]        new_shown;
	logic              lit;
	logic              at_or_above;

	// An attention request in solid mode is darkened; one in hardware mode with an
	// on time and no off time becomes a solid blue request.
	always_comb begin
		rgb_fix  = req.rgb;
		mode_fix = req.flash_mode;
		if (req.slot == plm_pkg::SLOT_ATTENTION) begin
			if (req.flash_mode == plm_pkg::FLASH_SOLID) begin
				rgb_fix = 24'd0;
			end else if (req.flash_mode == plm_pkg::FLASH_HW && req.on_time != 16'd0
					&& req.off_time == 16'd0) begin
				mode_fix = plm_pkg::FLASH_SOLID;
				rgb_fix  = plm_pkg::ATTN_FIX_COLOR;
			end
		end
		reject_in = (req.slot == plm_pkg::SLOT_NONE) || (mode_fix == plm_pkg::FLASH_INVALID);
	end

	always_comb begin
		unique case (req.slot)
			plm_pkg::SLOT_BATTERY: level_sel = level_q[0];
			plm_pkg::SLOT_NOTIFY:  level_sel = level_q[1];
			default:               level_sel = level_q[2];
		endcase
	end

	assign req.ready = (state_q == plm_pkg::TOP_IDLE);
	assign req_beat  = req.valid && req.ready;
	assign sc_start  = req_beat && !reject_in;

	plm_scaler u_scaler (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sc_start),
		.rgb    (rgb_fix),
		.level  (level_sel),
		.adjust (adjust_q),
		.stat   (sc_stat),
		.color  (sc_color)
	);

	// The result can leave once the output register is free or being emptied.
	assign commit = (state_q == plm_pkg::TOP_COMMIT) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			plm_pkg::TOP_IDLE: begin
				if (req_beat) begin
					state_d = reject_in ? plm_pkg::TOP_COMMIT : plm_pkg::TOP_CALC;
				end
			end
			plm_pkg::TOP_CALC: begin
				if (sc_stat.done) begin
					state_d = plm_pkg::TOP_COMMIT;
				end
			end
			plm_pkg::TOP_COMMIT: begin
				if (commit) begin
					state_d = plm_pkg::TOP_IDLE;
				end
			end
			default: state_d = plm_pkg::TOP_IDLE;
		endcase
	end

	// Choose what the LED shows after this request. A lit slot at or above the shown
	// one takes the LED. If the shown slot goes dark, the highest lit lower slot takes
	// over, or the LED goes off.
	assign lit         = (sc_color != 32'd0);
	assign at_or_above = !shown_v_q || (slot_q >= shown_q);

	always_comb begin
		out_status  = 1'b0;
		out_update  = 1'b0;
		out_color   = 32'd0;
		out_on      = 16'd0;
		out_off     = 16'd0;
		new_shown_v = shown_v_q;
		new_shown   = shown_q;
		priority if (reject_q) begin
			out_status = 1'b1;
		end else if (lit && at_or_above) begin
			out_update  = 1'b1;
			out_color   = sc_color;
			out_on      = on_q;
			out_off     = off_q;
			new_shown_v = 1'b1;
			new_shown   = slot_q;
		end else if (!lit && shown_v_q && shown_q == slot_q) begin
			out_update = 1'b1;
			priority if (slot_q == plm_pkg::SLOT_ATTENTION && slot_color_q[1] != 32'd0) begin
				out_color = slot_color_q[1];
				out_on    = slot_on_q[1];
				out_off   = slot_off_q[1];
				new_shown = plm_pkg::SLOT_NOTIFY;
			end else if (slot_q != plm_pkg::SLOT_BATTERY && slot_color_q[0] != 32'd0) begin
				out_color = slot_color_q[0];
				out_on    = slot_on_q[0];
				out_off   = slot_off_q[0];
				new_shown = plm_pkg::SLOT_BATTERY;
			end else begin
				new_shown_v = 1'b0;
			end
		end
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= plm_pkg::TOP_IDLE;
			adjust_q     <= {3{plm_pkg::FULL_SCALE}};
			level_q      <= {3{plm_pkg::FULL_SCALE}};
			slot_color_q <= '0;
			slot_on_q    <= '0;
			slot_off_q   <= '0;
			shown_v_q    <= 1'b0;
			shown_q      <= 2'd0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					plm_pkg::REG_ADJUST_RED:      adjust_q[0] <= cfg.data;
					plm_pkg::REG_ADJUST_GREEN:    adjust_q[1] <= cfg.data;
					plm_pkg::REG_ADJUST_BLUE:     adjust_q[2] <= cfg.data;
					plm_pkg::REG_LEVEL_BATTERY:   level_q[0]  <= cfg.data;
					plm_pkg::REG_LEVEL_NOTIFY:    level_q[1]  <= cfg.data;
					plm_pkg::REG_LEVEL_ATTENTION: level_q[2]  <= cfg.data;
					default: ;
				endcase
			end

			if (commit) begin
				rsp_valid_q <= 1'b1;
				shown_v_q   <= new_shown_v;
				shown_q     <= new_shown;
				if (!reject_q) begin
					slot_color_q[slot_q] <= sc_color;
					slot_on_q[slot_q]    <= on_q;
					slot_off_q[slot_q]   <= off_q;
				end
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request and result payload.
	always_ff @(posedge clk) begin
		if (req_beat) begin
			slot_q   <= req.slot;
			reject_q <= reject_in;
			// Solid mode clears the slot's blink times.
			if (mode_fix == plm_pkg::FLASH_SOLID) begin
				on_q  <= 16'd0;
				off_q <= 16'd0;
			end else begin
				on_q  <= req.on_time;
				off_q <= req.off_time;
			end
		end
		if (commit) begin
			status_q    <= out_status;
			update_q    <= out_update;
			color_out_q <= out_color;
			on_out_q    <= out_on;
			off_out_q   <= out_off;
			shown_out_q <= new_shown_v ? $signed({1'b0, new_shown}) : 3'sb111;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.led_update   = update_q;
	assign rsp.led_color    = color_out_q;
	assign rsp.led_on_time  = on_out_q;
	assign rsp.led_off_time = off_out_q;
	assign rsp.shown_slot   = shown_out_q;

	// The scaler is only started when it is free.
	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		sc_start |-> !sc_stat.busy)
		else $error("scaler started while busy");

	// A finished colour only arrives while the sequencer waits for it.
	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		sc_stat.done |-> state_q == plm_pkg::TOP_CALC)
		else $error("scaler finished outside the calculation state");

	// No request is taken while one is in work.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat |=> !req.ready)
		else $error("request taken while another is in work");

	// The shown slot is always a real one.
	a_shown_real: assert property (@(posedge clk) disable iff (!arst_n)
		shown_v_q |-> shown_q != plm_pkg::SLOT_NONE)
		else $error("slot three is shown");

	// A result held back by a full output register waits in the commit state.
	a_commit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == plm_pkg::TOP_COMMIT && rsp_valid_q && !rsp.ready)
		|=> state_q == plm_pkg::TOP_COMMIT)
		else $error("result lost while the output register was full");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the priority LED multiplexer: directed and random requests.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import plm_pkg::*;

	// Give up on a drain after this many cycles. Then let the block settle well past
	// its request latency.
	localparam int unsigned DRAIN_LIMIT     = 4000;
	localparam int unsigned SETTLE_CYCLES   = 40;
	localparam int unsigned ITEMS_PER_PHASE = 188;
	localparam int unsigned PHASES          = 6;

	// One LED request as it crosses the request channel.
	typedef struct packed {
		logic [1:0]  slot;
		logic [23:0] rgb;
		flash_mode_t mode;
		logic [15:0] on_ms;
		logic [15:0] off_ms;
	} led_request_t;

	// One response beat: the verdict and whatever was written to the LED.
	typedef struct packed {
		logic              status;
		logic              led_update;
		logic [31:0]       colour;
		logic [15:0]       on_ms;
		logic [15:0]       off_ms;
		logic signed [2:0] shown;
	} led_result_t;

	// The scoreboard keeps its own copy of the slot store, the calibration registers
	// and the shown slot. It works out the expected response as each request is taken,
	// and holds those responses in order until the block produces them.
	class led_scoreboard;
		logic [7:0]  adjust [3];
		logic [7:0]  level [3];
		logic [31:0] colour [3];
		logic [15:0] on_ms [3];
		logic [15:0] off_ms [3];
		int          shown;
		led_result_t expected_q [$];
		int unsigned failures, requests, checked, rewrites, rejects, handovers;

		function new();
			for (int i = 0; i < 3; i++) begin
				adjust[i] = FULL_SCALE;
				level[i]  = FULL_SCALE;
				colour[i] = '0;
				on_ms[i]  = '0;
				off_ms[i] = '0;
			end
			shown = -1;
		endfunction

		function void report(string what);
			failures++;
			$display("[%0t] ERROR: %s", $time, what);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void write_register(cfg_reg_t idx, logic [7:0] value);
			case (idx)
				REG_ADJUST_RED:      adjust[0] = value;
				REG_ADJUST_GREEN:    adjust[1] = value;
				REG_ADJUST_BLUE:     adjust[2] = value;
				REG_LEVEL_BATTERY:   level[0]  = value;
				REG_LEVEL_NOTIFY:    level[1]  = value;
				REG_LEVEL_ATTENTION: level[2]  = value;
				default: ;
			endcase
		endfunction

		// A product of three bytes always fits in 32 bits, so the division is exact.
		function logic [31:0] scale_channel(logic [7:0] ch, logic [7:0] adj, logic [7:0] lvl);
			return (32'(ch) * 32'(adj) * 32'(lvl)) / 32'(FULL_SCALE);
		endfunction

		function void note_request(led_request_t rq);
			logic [1:0]  slot;
			logic [23:0] rgb;
			flash_mode_t mode;
			logic [7:0]  lvl;
			led_result_t res;
			slot = rq.slot;
			rgb  = rq.rgb;
			mode = rq.mode;
			res  = '0;
			requests++;
			// Attention requests are fixed up before anything else is looked at.
			if (slot == SLOT_ATTENTION) begin
				if (mode == FLASH_SOLID) begin
					rgb = '0;
				end else if (mode == FLASH_HW && rq.on_ms != 0 && rq.off_ms == 0) begin
					mode = FLASH_SOLID;
					rgb  = ATTN_FIX_COLOR;
				end
			end
			if (slot == SLOT_NONE || mode == FLASH_INVALID) begin
				res.status = 1'b1;
				rejects++;
			end else begin
				if (mode == FLASH_SOLID) begin
					on_ms[slot]  = '0;
					off_ms[slot] = '0;
				end else begin
					on_ms[slot]  = rq.on_ms;
					off_ms[slot] = rq.off_ms;
				end
				lvl = level[slot];
				colour[slot] = (scale_channel(rgb[23:16], adjust[0], lvl) << 16)
					+ (scale_channel(rgb[15:8], adjust[1], lvl) << 8)
					+ scale_channel(rgb[7:0], adjust[2], lvl);
				if (colour[slot] != 0) begin
					if (int'(slot) >= shown) begin
						shown          = int'(slot);
						res.led_update = 1'b1;
						res.colour     = colour[slot];
						res.on_ms      = on_ms[slot];
						res.off_ms     = off_ms[slot];
					end
				end else if (int'(slot) == shown) begin
					// The shown slot went dark: hand over to the highest lit lower slot,
					// or switch the LED off if there is none.
					res.led_update = 1'b1;
					handovers++;
					shown = -1;
					for (int i = int'(slot) - 1; i >= 0; i--) begin
						if (shown < 0 && colour[i] != 0) begin
							shown      = i;
							res.colour = colour[i];
							res.on_ms  = on_ms[i];
							res.off_ms = off_ms[i];
						end
					end
				end
				if (res.led_update) begin
					rewrites++;
				end
			end
			res.shown = 3'(shown);
			expected_q.push_back(res);
		endfunction

		function void check_result(led_result_t got);
			led_result_t want;
			if (expected_q.size() == 0) begin
				report("response beat arrived with no request outstanding");
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.status !== want.status)
				report($sformatf("status %0b, expected %0b", got.status, want.status));
			if (got.led_update !== want.led_update)
				report($sformatf("led_update %0b, expected %0b", got.led_update,
					want.led_update));
			if (got.colour !== want.colour)
				report($sformatf("led_color %h, expected %h", got.colour, want.colour));
			if (got.on_ms !== want.on_ms)
				report($sformatf("led_on_time %h, expected %h", got.on_ms, want.on_ms));
			if (got.off_ms !== want.off_ms)
				report($sformatf("led_off_time %h, expected %h", got.off_ms, want.off_ms));
			if (got.shown !== want.shown)
				report($sformatf("shown_slot %0d, expected %0d", got.shown, want.shown));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	// While set, neither the request side nor the response side idles.
	logic steady;

	plm_req_if req_bus ();
	plm_rsp_if rsp_bus ();
	plm_cfg_if cfg_bus ();

	led_scoreboard sb = new();

	priority_led_multiplexer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// The response sink stalls at random, about six times in a hundred, except during the
	// steady stretch, where it takes every beat at once.
	initial begin
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_bus.ready <= steady || ($urandom_range(99) >= 6);
		end
	end

	// All three channels are watched at the rising edge, before any of this edge's
	// updates land, so each handshake is seen with the values that made it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				sb.check_result('{rsp_bus.status, rsp_bus.led_update, rsp_bus.led_color,
					rsp_bus.led_on_time, rsp_bus.led_off_time, rsp_bus.shown_slot});
			end
			if (req_bus.valid && req_bus.ready) begin
				sb.note_request('{req_bus.slot, req_bus.rgb,
					flash_mode_t'(req_bus.flash_mode), req_bus.on_time, req_bus.off_time});
			end
			if (cfg_bus.valid && cfg_bus.ready) begin
				sb.write_register(cfg_reg_t'(cfg_bus.index), cfg_bus.data);
			end
		end
	end

	function automatic led_request_t build_request(logic [1:0] slot, logic [23:0] rgb,
		flash_mode_t mode, logic [15:0] on_ms, logic [15:0] off_ms);
		led_request_t rq;
		rq.slot   = slot;
		rq.rgb    = rgb;
		rq.mode   = mode;
		rq.on_ms  = on_ms;
		rq.off_ms = off_ms;
		return rq;
	endfunction

	// Random requests are mostly well formed. Dark colours come often enough that
	// handovers and switch-offs keep happening, and a quarter of the requests have no off
	// time, so the attention slot also gets the hardware case that becomes a solid colour.
	function automatic led_request_t random_request();
		led_request_t rq;
		int unsigned  pick;
		rq.slot = ($urandom_range(99) < 5) ? SLOT_NONE : 2'($urandom_range(2));
		pick = $urandom_range(99);
		if (pick < 8)
			rq.mode = FLASH_INVALID;
		else if (pick < 35)
			rq.mode = FLASH_SOLID;
		else if (pick < 65)
			rq.mode = FLASH_TIMED;
		else
			rq.mode = FLASH_HW;
		pick = $urandom_range(99);
		if (pick < 25)
			rq.rgb = '0;
		else if (pick < 45)
			rq.rgb = 24'($urandom_range(255)) << (8 * $urandom_range(2));
		else
			rq.rgb = 24'($urandom);
		rq.on_ms  = ($urandom_range(99) < 15) ? 16'h0 : 16'($urandom);
		rq.off_ms = ($urandom_range(99) < 25) ? 16'h0 : 16'($urandom);
		return rq;
	endfunction

	// Presents one request and returns at the edge that takes it. Valid stays high on
	// return, so back-to-back requests need no gap.
	task automatic send_request(input led_request_t rq);
		while (!steady && $urandom_range(99) < 6) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
		req_bus.valid      <= 1'b1;
		req_bus.slot       <= rq.slot;
		req_bus.rgb        <= rq.rgb;
		req_bus.flash_mode <= rq.mode;
		req_bus.on_time    <= rq.on_ms;
		req_bus.off_time   <= rq.off_ms;
		@(posedge clk);
		while (!req_bus.ready) @(posedge clk);
	endtask

	task automatic write_register(input cfg_reg_t idx, input logic [7:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
	endtask

	task automatic program_levels(input logic [7:0] adj_r, input logic [7:0] adj_g,
		input logic [7:0] adj_b, input logic [7:0] lvl_bat, input logic [7:0] lvl_ntf,
		input logic [7:0] lvl_att);
		write_register(REG_ADJUST_RED, adj_r);
		write_register(REG_ADJUST_GREEN, adj_g);
		write_register(REG_ADJUST_BLUE, adj_b);
		write_register(REG_LEVEL_BATTERY, lvl_bat);
		write_register(REG_LEVEL_NOTIFY, lvl_ntf);
		write_register(REG_LEVEL_ATTENTION, lvl_att);
		cfg_bus.valid <= 1'b0;
	endtask

	// Drops the request valid, waits for every outstanding response and then lets the
	// block settle, so that the registers may safely be rewritten afterwards. The
	// first wait lets the monitor note the request taken at the current edge.
	task automatic drain_requests();
		int unsigned waited;
		req_bus.valid <= 1'b0;
		waited = 0;
		@(posedge clk);
		while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (sb.pending() != 0) begin
			sb.report($sformatf("%0d responses still outstanding after %0d cycles",
				sb.pending(), waited));
			sb.expected_q.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		steady             = 1'b0;
		arst_n             <= 1'b0;
		req_bus.valid      <= 1'b0;
		req_bus.slot       <= '0;
		req_bus.rgb        <= '0;
		req_bus.flash_mode <= FLASH_SOLID;
		req_bus.on_time    <= '0;
		req_bus.off_time   <= '0;
		cfg_bus.valid      <= 1'b0;
		cfg_bus.index      <= REG_ADJUST_RED;
		cfg_bus.data       <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, at the reset calibration. It walks the LED up through the
		// slots and back down again, with the extremes of every field on the way.
		// Full white on the battery slot, with the longest times.
		send_request(build_request(SLOT_BATTERY, 24'hffffff, FLASH_TIMED, 16'hffff, 16'hffff));
		// Notification takes over in hardware mode with zero times.
		send_request(build_request(SLOT_NOTIFY, 24'h010203, FLASH_HW, 16'h0, 16'h0));
		// A lit lower slot is stored but does not reach the LED.
		send_request(build_request(SLOT_BATTERY, 24'h000001, FLASH_SOLID, 16'h1234, 16'h4321));
		// A solid attention request is forced dark, so nothing changes on the LED.
		send_request(build_request(SLOT_ATTENTION, 24'hffffff, FLASH_SOLID, 16'h10, 16'h10));
		// Hardware mode with an on time and no off time turns into solid blue.
		send_request(build_request(SLOT_ATTENTION, 24'h00ff00, FLASH_HW, 16'd100, 16'h0));
		// Hardware mode with no on time is left as it is.
		send_request(build_request(SLOT_ATTENTION, 24'h800000, FLASH_HW, 16'h0, 16'h0));
		// Attention goes dark: the LED falls back to notification.
		send_request(build_request(SLOT_ATTENTION, 24'h000000, FLASH_TIMED, 16'h5, 16'h6));
		// An invalid flash mode and the missing fourth slot are both rejected.
		send_request(build_request(SLOT_NOTIFY, 24'hffffff, FLASH_INVALID, 16'hffff, 16'h1));
		send_request(build_request(SLOT_NONE, 24'hffffff, FLASH_TIMED, 16'hffff, 16'hffff));
		// Notification goes dark: battery is next in line.
		send_request(build_request(SLOT_NOTIFY, 24'h000000, FLASH_SOLID, 16'h0, 16'h0));
		// Battery goes dark with nothing below it, so the LED switches off.
		send_request(build_request(SLOT_BATTERY, 24'h000000, FLASH_TIMED, 16'h1, 16'h1));
		// A dark slot that is not shown leaves the LED alone.
		send_request(build_request(SLOT_BATTERY, 24'h000000, FLASH_TIMED, 16'h2, 16'h2));
		send_request(build_request(SLOT_NOTIFY, 24'haaaaaa, FLASH_TIMED, 16'h5555, 16'haaaa));
		send_request(build_request(SLOT_NOTIFY, 24'h555555, FLASH_TIMED, 16'haaaa, 16'h5555));
		send_request(build_request(SLOT_BATTERY, 24'hffffff, FLASH_TIMED, 16'h7fff, 16'h8000));
		// Hardware mode keeps its colour when an off time is given.
		send_request(build_request(SLOT_ATTENTION, 24'hff00ff, FLASH_HW, 16'hffff, 16'hffff));
		send_request(build_request(SLOT_ATTENTION, 24'h123456, FLASH_INVALID, 16'h1, 16'h0));
		send_request(build_request(SLOT_NONE, 24'h000000, FLASH_INVALID, 16'h0, 16'h0));
		send_request(build_request(SLOT_ATTENTION, 24'h000000, FLASH_TIMED, 16'h0, 16'h0));
		send_request(build_request(SLOT_NOTIFY, 24'h000000, FLASH_TIMED, 16'h0, 16'h0));
		send_request(build_request(SLOT_BATTERY, 24'h000000, FLASH_SOLID, 16'h0, 16'h0));
		drain_requests();

		// Random part, one calibration setting per phase. The third phase runs with
		// no idling on either side.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: program_levels(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
				1: program_levels(8'hff, 8'hff, 8'hff, 8'h01, 8'h01, 8'h01);
				2: program_levels(8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom), 8'($urandom));
				3: program_levels(8'hff, 8'h80, 8'h01, 8'h00, 8'hff, 8'h80);
				4: program_levels(8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom_range(255, 128)), 8'($urandom_range(127)), 8'($urandom));
				default: program_levels(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
			endcase
			steady = (phase == 2);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				send_request(random_request());
			end
			drain_requests();
		end
		steady = 1'b0;

		$display("Run covered %0d requests over %0d calibration settings; %0d responses checked.",
			sb.requests, PHASES + 1, sb.checked);
		$display("Of these, %0d rewrote the LED (%0d handovers or switch-offs), %0d were rejected.",
			sb.rewrites, sb.handovers, sb.rejects);
		if (sb.failures == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog: the slowest correct run takes well under a millisecond.
	initial begin
		#20ms;
		$display("Watchdog expired with %0d responses outstanding.", sb.pending());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
